[design/depth_pixel_backprojection_core_defines.svh]
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent completes.
`define DPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dpb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

  // Field widths
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned DEPTH_W        = 16;
  localparam int unsigned COLOR_W        = 8;
  localparam int unsigned CTR_W          = 20;
  localparam int unsigned CTR_FRAC       = 8;
  localparam int unsigned RECIP_W        = 32;
  localparam int unsigned QW             = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X        = 3'd0,
    CFG_CENTER_Y        = 3'd1,
    CFG_INV_FOCAL_X     = 3'd2,
    CFG_INV_FOCAL_Y     = 3'd3,
    CFG_INV_DEPTH_SCALE = 3'd4,
    CFG_NEAR_LIMIT      = 3'd5,
    CFG_FAR_LIMIT       = 3'd6
  } cfg_idx_t;

  // Register reset values
  localparam logic [CTR_W-1:0]   RST_CENTER_X        = 20'd81562;
  localparam logic [CTR_W-1:0]   RST_CENTER_Y        = 20'd65357;
  localparam logic [RECIP_W-1:0] RST_INV_FOCAL_X     = 32'd8302662;
  localparam logic [RECIP_W-1:0] RST_INV_FOCAL_Y     = 32'd8315522;
  localparam logic [RECIP_W-1:0] RST_INV_DEPTH_SCALE = 32'd858993;
  localparam logic [QW-1:0]      RST_NEAR_LIMIT      = 32'd13107;
  localparam logic [QW-1:0]      RST_FAR_LIMIT       = 32'd196608;

  typedef struct packed {
    logic [CTR_W-1:0]   center_x;
    logic [CTR_W-1:0]   center_y;
    logic [RECIP_W-1:0] inv_focal_x;
    logic [RECIP_W-1:0] inv_focal_y;
    logic [RECIP_W-1:0] inv_depth_scale;
    logic [QW-1:0]      near_limit;
    logic [QW-1:0]      far_limit;
  } cfg_t;

  // Per-stage load enables, shared by every unit of the pipeline.
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;
  } stage_ctrl_t;

endpackage

`default_nettype wire

[design/dpb_pixel_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dpb_pixel_if #(
  parameter int unsigned COORD_BITS = dpb_pkg::COORD_BITS_DEF
);
  import dpb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DEPTH_W-1:0]    depth_code;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic [COLOR_W-1:0]    red;
  logic [COLOR_W-1:0]    green;
  logic [COLOR_W-1:0]    blue;

  modport source (
    output valid, depth_code, column, row, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, depth_code, column, row, red, green, blue,
    output ready
  );

endinterface

`default_nettype wire

[design/dpb_point_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dpb_point_if;
  import dpb_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [QW-1:0] point_x;
  logic signed [QW-1:0] point_y;
  logic [QW-1:0]      point_z;
  logic [COLOR_W-1:0] point_red;
  logic [COLOR_W-1:0] point_green;
  logic [COLOR_W-1:0] point_blue;

  modport source (
    output valid, point_x, point_y, point_z, point_red, point_green, point_blue,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, point_red, point_green, point_blue,
    output ready
  );

endinterface

`default_nettype wire

[design/depth_pixel_backprojection_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake            | Beat contents
// in_pix    | in  | valid / ready        | depth_code, column, row, red, green, blue
// out_pt    | out | valid / ready        | point_x, point_y, point_z, point_*color
// cfg_*     | in  | cfg_we (no ready)    | cfg_index, cfg_wdata
//
// Four register stages; a kept pixel shows up on out_pt from the stage 4 register,
// and one beat can be taken every cycle while out_pt does not stall.
// Stage 1 scales the depth, stage 2 range-checks z and multiplies it into the x and y
// offsets, stage 3 applies the focal reciprocals, stage 4 floors and saturates.
// rst_n is synchronous: it empties the pipeline and restores the camera registers.
// An output stall holds only full stages, so in_pix.ready stays high while a bubble remains.
module depth_pixel_backprojection_core #(
  parameter int unsigned COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dpb_pixel_if.sink                       in_pix,
  dpb_point_if.source                     out_pt,
  input  logic                            cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dpb_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  cfg_t        cfg;
  stage_ctrl_t ctrl;

  // Valid bits, one per stage; stage 4 is the output register.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [QW-1:0] z;
  logic          keep;
  logic [QW-1:0] z2_r, z3_r, z4_r;
  color_t        c1_r, c2_r, c3_r, c4_r;
  logic signed [QW-1:0] px, py;

  dpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A stage may load when it is empty or when its content moves on this cycle.
  assign rdy4 = !v4_r || out_pt.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ctrl.s1_load = rdy1;
  assign ctrl.s2_load = rdy2;
  assign ctrl.s3_load = rdy3;
  assign ctrl.s4_load = rdy4;

  assign in_pix.ready = rdy1;

  dpb_depth_unit u_depth (
    .clk             (clk),
    .ctrl            (ctrl),
    .depth_code      (in_pix.depth_code),
    .inv_depth_scale (cfg.inv_depth_scale),
    .near_limit      (cfg.near_limit),
    .far_limit       (cfg.far_limit),
    .z               (z),
    .keep            (keep)
  );

  dpb_project_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .pix   (in_pix.column),
    .ctr   (cfg.center_x),
    .inv   (cfg.inv_focal_x),
    .z     (z),
    .coord (px)
  );

  dpb_project_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .pix   (in_pix.row),
    .ctr   (cfg.center_y),
    .inv   (cfg.inv_focal_y),
    .z     (z),
    .coord (py)
  );

  // Rejected pixels (no depth, or z outside the limits) turn into bubbles at
  // the end of stage 2 and never reach the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_pix.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r && keep;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  // Depth and color ride alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      c1_r <= '{red: in_pix.red, green: in_pix.green, blue: in_pix.blue};
    end
    if (rdy2) begin
      c2_r <= c1_r;
      z2_r <= z;
    end
    if (rdy3) begin
      c3_r <= c2_r;
      z3_r <= z2_r;
    end
    if (rdy4) begin
      c4_r <= c3_r;
      z4_r <= z3_r;
    end
  end

  assign out_pt.valid       = v4_r;
  assign out_pt.point_x     = px;
  assign out_pt.point_y     = py;
  assign out_pt.point_z     = z4_r;
  assign out_pt.point_red   = c4_r.red;
  assign out_pt.point_green = c4_r.green;
  assign out_pt.point_blue  = c4_r.blue;

endmodule

`default_nettype wire

[design/dpb_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dpb_pkg::cfg_t                   cfg
);
  import dpb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes to an index past the register list leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:        cfg_nxt.center_x        = cfg_wdata[CTR_W-1:0];
        CFG_CENTER_Y:        cfg_nxt.center_y        = cfg_wdata[CTR_W-1:0];
        CFG_INV_FOCAL_X:     cfg_nxt.inv_focal_x     = cfg_wdata[RECIP_W-1:0];
        CFG_INV_FOCAL_Y:     cfg_nxt.inv_focal_y     = cfg_wdata[RECIP_W-1:0];
        CFG_INV_DEPTH_SCALE: cfg_nxt.inv_depth_scale = cfg_wdata[RECIP_W-1:0];
        CFG_NEAR_LIMIT:      cfg_nxt.near_limit      = cfg_wdata[QW-1:0];
        CFG_FAR_LIMIT:       cfg_nxt.far_limit       = cfg_wdata[QW-1:0];
        default:             cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x        <= RST_CENTER_X;
      cfg_r.center_y        <= RST_CENTER_Y;
      cfg_r.inv_focal_x     <= RST_INV_FOCAL_X;
      cfg_r.inv_focal_y     <= RST_INV_FOCAL_Y;
      cfg_r.inv_depth_scale <= RST_INV_DEPTH_SCALE;
      cfg_r.near_limit      <= RST_NEAR_LIMIT;
      cfg_r.far_limit       <= RST_FAR_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[design/dpb_depth_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpb_depth_unit (
  input  logic                          clk,
  input  dpb_pkg::stage_ctrl_t          ctrl,
  input  logic [dpb_pkg::DEPTH_W-1:0]   depth_code,
  input  logic [dpb_pkg::RECIP_W-1:0]   inv_depth_scale,
  input  logic [dpb_pkg::QW-1:0]        near_limit,
  input  logic [dpb_pkg::QW-1:0]        far_limit,
  output logic [dpb_pkg::QW-1:0]        z,
  output logic                          keep
);
  import dpb_pkg::*;

  localparam int unsigned PROD_W = DEPTH_W + RECIP_W;
  localparam int unsigned Z_LSB  = PROD_W - QW;

  logic [PROD_W-1:0] prod_r;
  logic              nz_r;

  // Stage 1 scales the depth code; stage 2 slices out z and range-checks it.
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      prod_r <= PROD_W'(depth_code) * PROD_W'(inv_depth_scale);
      nz_r   <= (depth_code != '0);
    end
  end

  assign z    = prod_r[PROD_W-1:Z_LSB];
  assign keep = nz_r && (z >= near_limit) && (z <= far_limit);

endmodule

`default_nettype wire

[design/dpb_project_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpb_project_lane #(
  parameter int unsigned COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  dpb_pkg::stage_ctrl_t              ctrl,
  input  logic [COORD_BITS-1:0]             pix,
  input  logic [dpb_pkg::CTR_W-1:0]         ctr,
  input  logic [dpb_pkg::RECIP_W-1:0]       inv,
  input  logic [dpb_pkg::QW-1:0]            z,
  output logic signed [dpb_pkg::QW-1:0]     coord
);
  import dpb_pkg::*;

  localparam int unsigned POS_W = COORD_BITS + CTR_FRAC;
  localparam int unsigned MAG_W = (POS_W > CTR_W) ? POS_W : CTR_W;
  localparam int unsigned M_W   = MAG_W + QW;
  localparam int unsigned LO_W  = 2 * RECIP_W;
  localparam int unsigned HI_W  = (M_W - RECIP_W) + RECIP_W;
  localparam int unsigned T_W   = HI_W + 1;
  localparam int unsigned SH    = 8;
  localparam int unsigned Q_W   = T_W - SH;

  logic [MAG_W-1:0] pos;
  logic [MAG_W-1:0] ctr_ext;
  logic             neg1_r, neg2_r, neg3_r;
  logic [MAG_W-1:0] mag1_r;
  logic [M_W-1:0]   m2_r;
  logic [LO_W-1:0]  lo3_r;
  logic [HI_W-1:0]  hi3_r;
  logic [T_W-1:0]   t;
  logic [Q_W-1:0]   q;
  logic             round_up;
  logic [Q_W:0]     qn;
  logic [QW-1:0]    coord_nxt;
  logic [QW-1:0]    coord_r;

  assign pos     = MAG_W'({pix, CTR_FRAC'(0)});
  assign ctr_ext = MAG_W'(ctr);

  always_ff @(posedge clk) begin
    // Stage 1: signed offset from the principal point, kept as sign and magnitude.
    if (ctrl.s1_load) begin
      neg1_r <= (pos < ctr_ext);
      mag1_r <= (pos < ctr_ext) ? (ctr_ext - pos) : (pos - ctr_ext);
    end
    // Stage 2: offset times depth.
    if (ctrl.s2_load) begin
      neg2_r <= neg1_r;
      m2_r   <= M_W'(mag1_r) * M_W'(z);
    end
    // Stage 3: the wide product times the reciprocal, as two partial products.
    if (ctrl.s3_load) begin
      neg3_r <= neg2_r;
      lo3_r  <= LO_W'(m2_r[RECIP_W-1:0]) * LO_W'(inv);
      hi3_r  <= HI_W'(m2_r[M_W-1:RECIP_W]) * HI_W'(inv);
    end
    // Stage 4: merged, floored and saturated result.
    if (ctrl.s4_load) begin
      coord_r <= coord_nxt;
    end
  end

  // A negative result floors away from zero, so any discarded bit rounds the
  // magnitude up before negation.
  always_comb begin
    t        = T_W'(hi3_r) + T_W'(lo3_r[LO_W-1:RECIP_W]);
    q        = t[T_W-1:SH];
    round_up = neg3_r && ((t[SH-1:0] != '0) || (lo3_r[RECIP_W-1:0] != '0));
    qn       = (Q_W + 1)'(q) + (Q_W + 1)'(round_up);
    if (neg3_r) begin
      if (qn[Q_W:QW-1] != '0) begin
        coord_nxt = {1'b1, (QW - 1)'(0)};
      end else begin
        coord_nxt = QW'(0) - qn[QW-1:0];
      end
    end else begin
      if (q[Q_W-1:QW-1] != '0) begin
        coord_nxt = {1'b0, {(QW - 1){1'b1}}};
      end else begin
        coord_nxt = q[QW-1:0];
      end
    end
  end

  assign coord = signed'(coord_r);

endmodule

`default_nettype wire

[design/dpb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "depth_pixel_backprojection_core_defines.svh"

module dpb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z
);

  logic quiet;

  // No beat taken while the output side drains freely.
  assign quiet = !(in_valid && in_ready) && out_ready;

  // An empty or draining output register means the whole pipeline can move.
  `DPB_ASSERT_IMP(a_ready_free, (!out_valid || out_ready), in_ready, "input stalled with free output")

  // A quiet run that lasts through every stage flushes the pipeline, so no point may appear afterward.
  `DPB_ASSERT_NXT(a_drain, quiet ##1 quiet ##1 quiet ##1 quiet, !out_valid, "point without a pixel")

  // A refused point stays on the port unchanged.
  `DPB_ASSERT_NXT(a_hold, (out_valid && !out_ready), (out_valid && $stable(point_x) && $stable(point_y) && $stable(point_z)), "stalled point changed")

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pt.valid),
  .out_ready (out_pt.ready),
  .point_x   (out_pt.point_x),
  .point_y   (out_pt.point_y),
  .point_z   (out_pt.point_z)
);

`default_nettype wire

[tb/tb_depth_pixel_backprojection_core.sv]
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection_core;
  import dpb_pkg::*;

  localparam int unsigned COORD_BITS = COORD_BITS_DEF;
  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;

  // Index that lies past the register list; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // Rejected pixels leave no trace at the output, so after the last point we
  // still let the stages empty for SETTLE_CYCLES before the camera registers
  // are touched.
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned DRAIN_LIMIT      = 4000;
  localparam int unsigned LONG_HOLD_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT      = 500000;

  typedef struct {
    logic [DEPTH_W-1:0]    depth_code;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
  } pixel_t;

  typedef struct {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic [QW-1:0]        z;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } point_t;

  // Flavors of camera setup used by the random phases.
  typedef enum int {
    CAM_PLAIN,
    CAM_UNIT_SCALE,
    CAM_WILD,
    CAM_EXTREME
  } cam_style_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dpb_pixel_if #(.COORD_BITS(COORD_BITS)) pix_if ();
  dpb_point_if                            pt_if ();

  depth_pixel_backprojection_core #(.COORD_BITS(COORD_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_if.sink),
    .out_pt   (pt_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Our own copy of the camera registers, kept in step with every write.
  cfg_t       cam;
  cam_style_t cur_style = CAM_PLAIN;

  // Points that the block owes us, oldest first.
  point_t pending_points[$];

  int unsigned mismatches     = 0;
  int unsigned beats_sent     = 0;
  int unsigned points_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned cycles         = 0;

  // Idling controls. The main flow turns idling on and off per stretch; the
  // long output hold-off is requested by count and carried out by the sink.
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;
  int unsigned hold_reqs    = 0;
  int unsigned holds_done   = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One axis of the pinhole back-projection. The offset from the principal
  // point is carried in Q.8, multiplied exactly by depth (Q16.16) and by the
  // reciprocal focal length (Q0.32), so the product has 56 fraction bits; an
  // arithmetic shift by 40 floors it to Q16.16 toward minus infinity. The
  // product stays below 2^85, so 128 signed bits hold it with room to spare.
  function automatic logic [QW-1:0] project_axis(logic [COORD_BITS-1:0] pix,
                                                 logic [CTR_W-1:0] ctr,
                                                 logic [QW-1:0] z,
                                                 logic [RECIP_W-1:0] inv);
    logic signed [127:0] pos_q8, ctr_q8, z_w, inv_w, prod, q;
    pos_q8 = 128'(pix) << CTR_FRAC;
    ctr_q8 = 128'(ctr);
    z_w    = 128'(z);
    inv_w  = 128'(inv);
    prod   = (pos_q8 - ctr_q8) * z_w * inv_w;
    q      = prod >>> 40;
    if (q > 128'sd2147483647)
      return 32'h7FFF_FFFF;
    if (q < -128'sd2147483648)
      return 32'h8000_0000;
    return q[QW-1:0];
  endfunction

  // Returns 1 and fills pt when the pixel should become a point.
  function automatic bit backproject_pixel(pixel_t p, output point_t pt);
    logic [47:0]   scaled;
    logic [QW-1:0] z;
    pt = '{default: '0};
    // No measurement never yields a point, whatever the depth window says.
    if (p.depth_code == '0)
      return 1'b0;
    scaled = p.depth_code * cam.inv_depth_scale;
    z      = scaled[47:16];
    // Inclusive window; crossed limits reject everything.
    if (z < cam.near_limit || z > cam.far_limit)
      return 1'b0;
    pt.x     = project_axis(p.column, cam.center_x, z, cam.inv_focal_x);
    pt.y     = project_axis(p.row, cam.center_y, z, cam.inv_focal_y);
    pt.z     = z;
    pt.red   = p.red;
    pt.green = p.green;
    pt.blue  = p.blue;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pixel_t make_pixel(int unsigned d, int unsigned u, int unsigned v,
                                        int unsigned r, int unsigned g, int unsigned b);
    pixel_t p;
    p.depth_code = DEPTH_W'(d);
    p.column     = COORD_BITS'(u);
    p.row        = COORD_BITS'(v);
    p.red        = COLOR_W'(r);
    p.green      = COLOR_W'(g);
    p.blue       = COLOR_W'(b);
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    p = make_pixel($urandom_range(1, 65535), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom, $urandom, $urandom);
    if (pick == 0) begin
      p.depth_code = '0;
    end else if (pick <= 4 && cur_style == CAM_UNIT_SCALE) begin
      // With a unit depth scale z equals the code, so we can sit right on
      // either edge of the depth window or one step outside it.
      case ($urandom_range(0, 3))
        0: p.depth_code = DEPTH_W'(cam.near_limit - 1);
        1: p.depth_code = DEPTH_W'(cam.near_limit);
        2: p.depth_code = DEPTH_W'(cam.far_limit);
        default: p.depth_code = DEPTH_W'(cam.far_limit + 1);
      endcase
    end else if (pick == 5) begin
      p.column = $urandom_range(0, 1) ? '1 : '0;
      p.row    = $urandom_range(0, 1) ? '1 : '0;
    end
    return p;
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t pick_camera(cam_style_t s);
    cfg_t        c;
    logic [31:0] scale;
    c.center_x    = CTR_W'($urandom);
    c.center_y    = CTR_W'($urandom);
    c.inv_focal_x = $urandom >> $urandom_range(0, 24);
    c.inv_focal_y = $urandom >> $urandom_range(0, 24);
    case (s)
      CAM_PLAIN: begin
        // z spans roughly scale/2^16 up to scale, so a window tied to the
        // scale keeps most pixels and trims a few at each end.
        scale             = $urandom >> $urandom_range(0, 16);
        c.inv_depth_scale = scale;
        c.near_limit      = scale >> $urandom_range(10, 31);
        c.far_limit       = scale - (scale >> $urandom_range(1, 6));
      end
      CAM_UNIT_SCALE: begin
        c.inv_depth_scale = 32'h0001_0000;
        c.near_limit      = $urandom_range(1, 30000);
        c.far_limit       = c.near_limit + $urandom_range(0, 35000);
      end
      CAM_WILD: begin
        c.center_x        = CTR_W'($urandom);
        c.inv_focal_x     = $urandom;
        c.inv_focal_y     = $urandom;
        c.inv_depth_scale = $urandom;
        c.near_limit      = $urandom >> $urandom_range(0, 31);
        c.far_limit       = $urandom;
      end
      default: begin
        c.center_x        = CTR_W'(corner_value());
        c.center_y        = CTR_W'(corner_value());
        c.inv_focal_x     = corner_value();
        c.inv_focal_y     = corner_value();
        c.inv_depth_scale = corner_value();
        c.near_limit      = $urandom_range(0, 1) ? '0 : corner_value();
        c.far_limit       = $urandom_range(0, 1) ? '1 : corner_value();
      end
    endcase
    return c;
  endfunction

  // One register write on the falling edge; the block takes it on the next
  // rising edge. Our copy follows the same masking as the hardware.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_CENTER_X:        cam.center_x        = data[CTR_W-1:0];
      CFG_CENTER_Y:        cam.center_y        = data[CTR_W-1:0];
      CFG_INV_FOCAL_X:     cam.inv_focal_x     = data;
      CFG_INV_FOCAL_Y:     cam.inv_focal_y     = data;
      CFG_INV_DEPTH_SCALE: cam.inv_depth_scale = data;
      CFG_NEAR_LIMIT:      cam.near_limit      = data;
      CFG_FAR_LIMIT:       cam.far_limit       = data;
      default: ;
    endcase
  endtask

  task automatic set_camera(cfg_t c);
    write_reg(CFG_CENTER_X, CFG_DATA_W'(c.center_x));
    write_reg(CFG_CENTER_Y, CFG_DATA_W'(c.center_y));
    write_reg(CFG_INV_FOCAL_X, c.inv_focal_x);
    write_reg(CFG_INV_FOCAL_Y, c.inv_focal_y);
    write_reg(CFG_INV_DEPTH_SCALE, c.inv_depth_scale);
    write_reg(CFG_NEAR_LIMIT, c.near_limit);
    write_reg(CFG_FAR_LIMIT, c.far_limit);
  endtask

  // Offers one pixel beat, optionally after a gap with valid low, and waits
  // until the block takes it. Valid is left high so that back-to-back beats
  // need no extra edge; the drain task lowers it.
  task automatic send_pixel(pixel_t p);
    int unsigned gap;
    point_t      pt;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      pix_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_if.valid      <= 1'b1;
    pix_if.depth_code <= p.depth_code;
    pix_if.column     <= p.column;
    pix_if.row        <= p.row;
    pix_if.red        <= p.red;
    pix_if.green      <= p.green;
    pix_if.blue       <= p.blue;
    do @(posedge clk); while (!pix_if.ready);
    beats_sent++;
    if (backproject_pixel(p, pt))
      pending_points.insert(pending_points.size(), pt);
  endtask

  // Waits until every owed point has arrived, then lets the stages empty.
  task automatic drain_pipeline();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_points.size() != 0; i++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endfunction

  // Every point beat taken at a rising edge is matched against the oldest
  // owed point; a beat with nothing owed is a failure of its own.
  always @(posedge clk) begin : point_checker
    point_t want;
    if (rst_n && pt_if.valid && pt_if.ready) begin
      if (pending_points.size() == 0) begin
        $error("point beat arrived with no point owed");
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        check_field("point_x", want.x, pt_if.point_x);
        check_field("point_y", want.y, pt_if.point_y);
        check_field("point_z", want.z, pt_if.point_z);
        check_field("point_red", 32'(want.red), 32'(pt_if.point_red));
        check_field("point_green", 32'(want.green), 32'(pt_if.point_green));
        check_field("point_blue", 32'(want.blue), 32'(pt_if.point_blue));
        points_checked++;
      end
    end
  end

  // Output pacing. A pending hold-off request wins: ready stays low for a
  // long, counted stretch while the sender keeps pushing, which fills every
  // stage and forces in_pix.ready low. Otherwise, with idling on, ready drops
  // for random bursts.
  initial begin : sink_pacing
    pt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        pt_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        pt_if.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        pt_if.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pixels against the power-up camera registers: this is where the reset
  // values get checked. Covers no measurement, both corners of the image,
  // color extremes, a depth past the far limit and one short of the near one.
  task automatic test_reset_camera();
    send_pixel(make_pixel(0, 100, 100, 1, 2, 3));
    send_pixel(make_pixel(5000, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(5000, COORD_MAX, COORD_MAX, 255, 255, 255));
    send_pixel(make_pixel(10000, 320, 240, 128, 64, 32));
    send_pixel(make_pixel(65535, 320, 240, 9, 9, 9));
    send_pixel(make_pixel(1, 320, 240, 7, 7, 7));
    drain_pipeline();
  endtask

  // Depth window edges with a unit scale so that z equals the depth code,
  // then crossed limits, then a zero scale which gives z = 0 and is only let
  // through because the near limit is zero.
  task automatic test_depth_window();
    cfg_t c;
    c                 = cam;
    c.inv_depth_scale = 32'h0001_0000;
    c.near_limit      = 100;
    c.far_limit       = 200;
    set_camera(c);
    send_pixel(make_pixel(99, 10, 20, 1, 1, 1));
    send_pixel(make_pixel(100, 10, 20, 2, 2, 2));
    send_pixel(make_pixel(200, 10, 20, 3, 3, 3));
    send_pixel(make_pixel(201, 10, 20, 4, 4, 4));
    drain_pipeline();

    write_reg(CFG_NEAR_LIMIT, 201);
    send_pixel(make_pixel(200, 10, 20, 5, 5, 5));
    send_pixel(make_pixel(201, 10, 20, 6, 6, 6));
    drain_pipeline();

    write_reg(CFG_INV_DEPTH_SCALE, '0);
    write_reg(CFG_NEAR_LIMIT, '0);
    send_pixel(make_pixel(1, 10, 20, 7, 7, 7));
    send_pixel(make_pixel(0, 10, 20, 8, 8, 8));
    drain_pipeline();
  endtask

  // Zero focal reciprocals force x and y to zero whatever the offset is.
  task automatic test_zero_reciprocal();
    cfg_t c;
    c                 = cam;
    c.inv_depth_scale = RST_INV_DEPTH_SCALE;
    c.inv_focal_x     = '0;
    c.inv_focal_y     = '0;
    c.near_limit      = '0;
    c.far_limit       = '1;
    set_camera(c);
    send_pixel(make_pixel(40000, 0, COORD_MAX, 10, 20, 30));
    send_pixel(make_pixel(65535, COORD_MAX, 0, 40, 50, 60));
    drain_pipeline();
  endtask

  // Largest reciprocals and scale drive x and y into both saturation rails.
  // The center column write carries junk above bit 19, which must be dropped,
  // and a write to an index past the list must leave the camera untouched.
  task automatic test_saturation();
    cfg_t c;
    c                 = cam;
    c.center_y        = '1;
    c.inv_focal_x     = '1;
    c.inv_focal_y     = '1;
    c.inv_depth_scale = '1;
    set_camera(c);
    write_reg(CFG_CENTER_X, 32'hFFF0_0000);
    send_pixel(make_pixel(65535, COORD_MAX, 0, 255, 0, 255));
    send_pixel(make_pixel(65535, 0, COORD_MAX, 0, 255, 0));
    send_pixel(make_pixel(3, 1, 1, 17, 34, 51));
    drain_pipeline();
    write_reg(CFG_SPARE_IDX, 32'h0000_0001);
    send_pixel(make_pixel(65535, COORD_MAX, 0, 1, 2, 3));
    drain_pipeline();
  endtask

  // Bulk random traffic across the four camera flavors. Phases that tend to
  // reject most pixels are kept short. Idling on each side is switched on or
  // off every fifty beats so that long clean stretches occur as well.
  task automatic test_random_stream();
    int unsigned count;
    for (int ph = 0; ph < 12; ph++) begin
      cur_style = cam_style_t'(ph % 4);
      set_camera(pick_camera(cur_style));
      count = (cur_style == CAM_PLAIN || cur_style == CAM_UNIT_SCALE) ? 180 : 40;
      for (int k = 0; k < count; k++) begin
        if (k % 50 == 0) begin
          src_idle_on  = $urandom_range(0, 3) != 0;
          sink_idle_on = $urandom_range(0, 3) != 0;
        end
        send_pixel(random_pixel());
      end
      drain_pipeline();
    end
  endtask

  // The receiver holds off for a long stretch while pixels keep coming, so
  // the pipeline fills and the input must stall without losing a beat.
  task automatic test_output_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    cur_style    = CAM_PLAIN;
    set_camera(pick_camera(CAM_PLAIN));
    hold_reqs++;
    for (int k = 0; k < 40; k++)
      send_pixel(random_pixel());
    drain_pipeline();
  endtask

  // Closing stretch with no idling at all: one beat per cycle end to end.
  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    cur_style    = CAM_PLAIN;
    set_camera(pick_camera(CAM_PLAIN));
    for (int k = 0; k < 200; k++)
      send_pixel(random_pixel());
    drain_pipeline();
  endtask

  // ---------------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_CENTER_X;
    cfg_wdata         = '0;
    pix_if.valid      = 1'b0;
    pix_if.depth_code = '0;
    pix_if.column     = '0;
    pix_if.row        = '0;
    pix_if.red        = '0;
    pix_if.green      = '0;
    pix_if.blue       = '0;

    cam.center_x        = RST_CENTER_X;
    cam.center_y        = RST_CENTER_Y;
    cam.inv_focal_x     = RST_INV_FOCAL_X;
    cam.inv_focal_y     = RST_INV_FOCAL_Y;
    cam.inv_depth_scale = RST_INV_DEPTH_SCALE;
    cam.near_limit      = RST_NEAR_LIMIT;
    cam.far_limit       = RST_FAR_LIMIT;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_camera();
    test_depth_window();
    test_zero_reciprocal();
    test_saturation();
    test_random_stream();
    test_output_backpressure();
    test_full_rate();

    if (pending_points.size() != 0) begin
      $error("%0d points never arrived", pending_points.size());
      mismatches += pending_points.size();
    end

    $display("Sent %0d pixel beats in %0d cycles through %0d register writes.",
             beats_sent, cycles, reg_writes);
    $display("Checked %0d points across window, saturation and stall cases.",
             points_checked);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
